// ----- rtl/core/dmx_rgb_channel_receiver_defines.svh -----
// ----------------------------------------------------------------------------
// DMX RGB channel receiver assertion macros
// Shared property forms for the checker; clk and rst are taken from scope.
// ----------------------------------------------------------------------------
`ifndef DMX_RGB_CHANNEL_RECEIVER_DEFINES_SVH
`define DMX_RGB_CHANNEL_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DMXRX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DMXRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dmxrx_pkg.sv -----
// ----------------------------------------------------------------------------
// DMX RGB channel receiver package
// Field widths, register indexes, divider constants and shared types.
// ----------------------------------------------------------------------------
package dmxrx_pkg;

  localparam int DATA_W      = 8;
  localparam int DUTY_W      = 16;
  localparam int START_W     = 9;
  localparam int PERIOD_W    = 16;
  localparam int SLOT_W      = 10;
  localparam int LANE_W      = 2;
  localparam int PROD_W      = 24;
  localparam int RECIP_W     = 49;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LANE_W-1:0] LANE_FIRST  = 2'd0;
  localparam logic [LANE_W-1:0] LANE_SECOND = 2'd1;
  localparam logic [LANE_W-1:0] LANE_LAST   = 2'd2;

  // floor(x / 255) == (x * DIV255_MUL) >> DIV255_SHIFT for every x below 2^24
  localparam logic [24:0] DIV255_MUL   = 25'h1010102;
  localparam int          DIV255_SHIFT = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_START_CHANNEL = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD    = 4'd1;

  localparam logic [START_W-1:0]  START_CHANNEL_RESET = 9'd0;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET    = 16'd1999;

  // One channel byte read from the frame store, zero when beyond the fill.
  typedef struct packed {
    logic              valid;
    logic [LANE_W-1:0] lane;
    logic [DATA_W-1:0] data;
  } beat_t;

endpackage

// ----- rtl/core/dmx_rgb_channel_receiver.sv -----
// ----------------------------------------------------------------------------
// DMX RGB channel receiver
// Captures a DMX-style frame from UART bytes and emits three PWM compares.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries received bytes: tdata is the byte, tuser the receive error
//   flag. An error request restarts the frame at slot 0; following good bytes
//   fill the frame store. A good byte arriving unarmed or with the store full
//   triggers one result on m_* if the start code is zero.
//   cfg_* writes start_channel (index 0) and pwm_period (index 1); cfg_ready
//   is always high. Write only while no result is pending.
// Requests: store, error and dropped requests are taken back to back unless a
//   read burst holds them. A result request reads the memory once per channel,
//   first, second then last lane; new requests are held until the edge that
//   issues the last read; a further result request waits for a free pipeline.
// Path: memory read register, product register, then the duty registers.
// Reset: clears the fill count, so the store reads as all zero at once with
//   no clearing pass; registers return to their reset values.
// Stall: the result waits in the output register; store and error requests
//   are still taken, a further result request waits until the output drains.
// ----------------------------------------------------------------------------
module dmx_rgb_channel_receiver
  import dmxrx_pkg::*;
#(
  parameter int FRAME_SLOTS = 512
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [DATA_W-1:0]       s_tdata,   // [7:0] rx_byte
  input  logic                    s_tuser,   // [0] rx_error
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [3*DUTY_W-1:0]     m_tdata,   // [15:0] duty_first, [31:16] duty_second,
                                             // [47:32] duty_third
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [START_W-1:0]  start_channel;
  logic [PERIOD_W-1:0] pwm_period;
  logic                res_room;
  logic                res_start;
  beat_t               beat;
  logic [DUTY_W-1:0]   duty_first;
  logic [DUTY_W-1:0]   duty_second;
  logic [DUTY_W-1:0]   duty_third;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_channel <= START_CHANNEL_RESET;
      pwm_period    <= PWM_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_CHANNEL: start_channel <= cfg_data[START_W-1:0];
        REG_PWM_PERIOD:    pwm_period    <= cfg_data[PERIOD_W-1:0];
        default:           pwm_period    <= pwm_period;
      endcase
    end
  end

  dmxrx_frame_ctrl #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_frame_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .start_channel (start_channel),
    .res_room      (res_room),
    .res_start     (res_start),
    .beat          (beat)
  );

  dmxrx_duty_calc u_duty_calc (
    .clk         (clk),
    .rst         (rst),
    .pwm_period  (pwm_period),
    .beat        (beat),
    .res_start   (res_start),
    .res_room    (res_room),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .duty_first  (duty_first),
    .duty_second (duty_second),
    .duty_third  (duty_third)
  );

  assign m_tdata = {duty_third, duty_second, duty_first};

endmodule

// ----- rtl/core/dmxrx_frame_ctrl.sv -----
// ----------------------------------------------------------------------------
// DMX RGB channel receiver frame control
// Classifies input requests, owns the frame store and reads three channels.
// ----------------------------------------------------------------------------
module dmxrx_frame_ctrl
  import dmxrx_pkg::*;
#(
  parameter int FRAME_SLOTS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [DATA_W-1:0]  s_tdata,
  input  logic               s_tuser,
  input  logic [START_W-1:0] start_channel,
  input  logic               res_room,
  output logic               res_start,
  output beat_t              beat
);

  localparam int AW   = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW   = $clog2(FRAME_SLOTS + 1);
  localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

  logic [DATA_W-1:0] mem [FRAME_SLOTS];
  logic [DATA_W-1:0] rdata;

  logic              armed;
  logic [CW-1:0]     slot_count;
  logic [CW-1:0]     fill;
  logic              start_zero;
  logic              rd_busy;
  logic [LANE_W-1:0] rd_lane;
  logic              rd_valid;
  logic [LANE_W-1:0] rd_lane_q;
  logic              rd_in_range;

  logic              is_store;
  logic              is_result;
  logic              rd_free;
  logic              accept;
  logic              wr_en;
  logic [SLOT_W-1:0] rd_slot;
  logic              slot_in_range;

  assign is_store  = !s_tuser && armed && (slot_count < CW'(FRAME_SLOTS));
  assign is_result = !s_tuser && !is_store && start_zero;
  // Hold new requests while a read burst still has lanes to issue.
  assign rd_free   = !rd_busy || (rd_lane == LANE_LAST);
  assign s_tready  = rd_free && (!is_result || res_room);
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && is_store;
  assign res_start = accept && is_result;

  assign rd_slot       = SLOT_W'(start_channel) + SLOT_W'(rd_lane);
  assign slot_in_range = CMPW'(rd_slot) < CMPW'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      slot_count <= '0;
      fill       <= '0;
      start_zero <= 1'b1;
    end else if (accept) begin
      if (s_tuser) begin
        armed      <= 1'b1;
        slot_count <= '0;
      end else if (is_store) begin
        slot_count <= slot_count + CW'(1);
        if (slot_count == fill) begin
          fill <= fill + CW'(1);
        end
        if (slot_count == '0) begin
          start_zero <= (s_tdata == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy  <= 1'b0;
      rd_lane  <= LANE_FIRST;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_busy;
      if (rd_busy) begin
        rd_lane <= rd_lane + LANE_W'(1);
        if (rd_lane == LANE_LAST) begin
          rd_busy <= 1'b0;
        end
      end
      if (res_start) begin
        rd_busy <= 1'b1;
        rd_lane <= LANE_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_count[AW-1:0]] <= s_tdata;
    end
    if (rd_busy) begin
      rdata <= mem[rd_slot[AW-1:0]];
    end
    rd_lane_q   <= rd_lane;
    rd_in_range <= slot_in_range;
  end

  // Slots never written since reset read as zero.
  always_comb begin
    beat.valid = rd_valid;
    beat.lane  = rd_lane_q;
    beat.data  = rd_in_range ? rdata : '0;
  end

endmodule

// ----- rtl/core/dmxrx_duty_calc.sv -----
// ----------------------------------------------------------------------------
// DMX RGB channel receiver duty calculator
// Scales channel bytes by the PWM period, divides by 255, holds the result.
// ----------------------------------------------------------------------------
module dmxrx_duty_calc
  import dmxrx_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [PERIOD_W-1:0] pwm_period,
  input  beat_t               beat,
  input  logic                res_start,
  output logic                res_room,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DUTY_W-1:0]   duty_first,
  output logic [DUTY_W-1:0]   duty_second,
  output logic [DUTY_W-1:0]   duty_third
);

  logic              pipe_busy;
  logic              p_valid;
  logic [LANE_W-1:0] p_lane;
  logic [PROD_W-1:0] prod;
  logic [RECIP_W-1:0] recip;
  logic [DUTY_W-1:0] quot;

  assign recip = RECIP_W'(prod) * RECIP_W'(DIV255_MUL);
  assign quot  = recip[DIV255_SHIFT+DUTY_W-1:DIV255_SHIFT];

  // One result in flight or waiting at a time.
  assign res_room = !pipe_busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_busy <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= beat.valid;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (res_start) begin
        pipe_busy <= 1'b1;
      end
      if (p_valid && (p_lane == LANE_LAST)) begin
        pipe_busy <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod   <= PROD_W'(beat.data) * PROD_W'(pwm_period);
    p_lane <= beat.lane;
    if (p_valid) begin
      case (p_lane)
        LANE_FIRST:  duty_first  <= quot;
        LANE_SECOND: duty_second <= quot;
        LANE_LAST:   duty_third  <= quot;
        default:     duty_third  <= duty_third;
      endcase
    end
  end

endmodule

// ----- rtl/core/dmxrx_port_checker.sv -----
// ----------------------------------------------------------------------------
// DMX RGB channel receiver port checker
// Watches the top-level streams over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "dmx_rgb_channel_receiver_defines.svh"

module dmxrx_port_checker
  import dmxrx_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [3*DUTY_W-1:0] m_tdata
);

  // A stalled result holds its value.
  `DMXRX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // The output register drains before the next result can land.
  `DMXRX_ASSERT_NEXT(a_out_gap, m_tvalid && m_tready, !m_tvalid, "result followed without a gap")

  // After an error request the next byte is always a store, so it is taken.
  `DMXRX_ASSERT_NEXT(a_err_ready, s_tvalid && s_tready && s_tuser, s_tready, "request after error stalled")

endmodule

bind dmx_rgb_channel_receiver dmxrx_port_checker u_port_checker (.*);

// ----- verif/dmx_rgb_channel_receiver_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DMX RGB channel receiver testbench
// Drives error-flagged bytes as whole frames, broken frames and stray bytes,
// predicts the PWM compare triples from a private copy of the frame store,
// and checks every result in order under random source and sink stalls.
// ----------------------------------------------------------------------------
module dmx_rgb_channel_receiver_tb;
  import dmxrx_pkg::*;

  localparam int          FRAME_SLOTS  = 512;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_TICKS = 10;
  localparam int unsigned RANDOM_UNTIL = 545;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_first;
    logic [DUTY_W-1:0] duty_second;
    logic [DUTY_W-1:0] duty_third;
  } duty_set_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [3*DUTY_W-1:0]    m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic [DATA_W-1:0]   frame_mem [FRAME_SLOTS];
  int unsigned         next_slot;
  bit                  rx_armed;
  logic [START_W-1:0]  cur_start;
  logic [PERIOD_W-1:0] cur_period;
  duty_set_t           duty_expect_q [$];

  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  dmx_rgb_channel_receiver #(
    .FRAME_SLOTS(FRAME_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one; none in a steady stretch
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DUTY_W-1:0] scale_duty(input int unsigned slot);
    logic [31:0] level;
    level = '0;
    if (slot < FRAME_SLOTS) level = 32'(frame_mem[slot]);
    return DUTY_W'((level * 32'(cur_period)) / 32'd255);
  endfunction

  // advance the predictor by one accepted request
  task automatic take_byte(input logic [DATA_W-1:0] rx_byte, input logic rx_error);
    duty_set_t duty;
    if (rx_error) begin
      rx_armed  = 1'b1;
      next_slot = 0;
    end else if (rx_armed && next_slot < FRAME_SLOTS) begin
      frame_mem[next_slot] = rx_byte;
      next_slot++;
    end else if (frame_mem[0] == '0) begin
      duty.duty_first  = scale_duty(cur_start);
      duty.duty_second = scale_duty(cur_start + 1);
      duty.duty_third  = scale_duty(cur_start + 2);
      duty_expect_q.push_back(duty);
    end
  endtask

  // sink side: random stalls
  always @(posedge clk) begin
    int unsigned stall_left;
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = idle_gap();
    end
  end

  always @(posedge clk) begin
    duty_set_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (duty_expect_q.size() == 0) begin
        $error("unexpected result: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = duty_expect_q.pop_front();
        if (m_tdata[DUTY_W-1:0] !== want.duty_first) begin
          $error("duty_first: expected %0d, actual %0d", want.duty_first,
                 m_tdata[DUTY_W-1:0]);
          fail_count++;
        end
        if (m_tdata[2*DUTY_W-1:DUTY_W] !== want.duty_second) begin
          $error("duty_second: expected %0d, actual %0d", want.duty_second,
                 m_tdata[2*DUTY_W-1:DUTY_W]);
          fail_count++;
        end
        if (m_tdata[3*DUTY_W-1:2*DUTY_W] !== want.duty_third) begin
          $error("duty_third: expected %0d, actual %0d", want.duty_third,
                 m_tdata[3*DUTY_W-1:2*DUTY_W]);
          fail_count++;
        end
      end
    end
  end

  // hold valid after the handshake; drop it only ahead of a gap
  task automatic send_byte(input logic [DATA_W-1:0] rx_byte, input logic rx_error);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx_byte;
    s_tuser  <= rx_error;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    take_byte(rx_byte, rx_error);
  endtask

  // pause the source until every pending result is out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic reg_write(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_START_CHANNEL) cur_start = value[START_W-1:0];
    else if (index == REG_PWM_PERIOD) cur_period = value[PERIOD_W-1:0];
  endtask

  task automatic set_config(input int unsigned start, input int unsigned period);
    drain();
    reg_write(REG_START_CHANNEL, CFG_DATA_W'(start));
    reg_write(REG_PWM_PERIOD, CFG_DATA_W'(period));
    cfg_valid <= 1'b0;
  endtask

  // break, start code, then the rest of the slots
  task automatic send_frame(input logic [DATA_W-1:0] start_code, input int unsigned len);
    send_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
    send_byte(start_code, 1'b0);
    for (int unsigned i = 1; i < len; i++) send_byte(pick_byte(), 1'b0);
  endtask

  task automatic send_good_bytes(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_byte(pick_byte(), 1'b0);
  endtask

  // before any break the store reads as zero and every good byte reports
  task automatic test_unarmed_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_full_frame();
    send_frame(8'h00, FRAME_SLOTS);
    send_good_bytes(4);
    drain();
    send_good_bytes(2);
  endtask

  // a nonzero start code lands in slot 0; the short frame keeps storing
  task automatic test_start_code_nonzero();
    send_frame(8'h80, 4);
    send_good_bytes(2);
  endtask

  // store still full with a zero start code; channels near and past the end
  task automatic test_config_extremes();
    int unsigned starts [4]  = '{509, 510, 511, 0};
    int unsigned periods [4] = '{65535, 0, 65535, 1};
    for (int i = 0; i < 4; i++) begin
      set_config(starts[i], periods[i]);
      send_good_bytes(2);
    end
  endtask

  // breaks in mid-frame restart at slot 0; older bytes past the new frame stay readable
  task automatic test_broken_frames();
    send_frame(8'h00, 3);
    send_frame(8'h00, 1);
    send_byte(8'h33, 1'b1);
    send_good_bytes(2);
  endtask

  // store full with a zero start code: every good byte reports
  task automatic test_random_frames();
    int unsigned start;
    int unsigned period;
    while (items_sent < RANDOM_UNTIL) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        start  = ($urandom_range(0, 9) < 3) ? 509 + $urandom_range(0, 2)
                                            : $urandom_range(0, 511);
        period = ($urandom_range(0, 9) < 3) ? (($urandom_range(0, 1) == 0) ? 0 : 65535)
                                            : $urandom_range(0, 65535);
        set_config(start, period);
      end
      send_good_bytes($urandom_range(2, 6));
      if ($urandom_range(0, 4) == 0) drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < FRAME_SLOTS; i++) frame_mem[i] = '0;
    next_slot  = 0;
    rx_armed   = 1'b0;
    cur_start  = START_CHANNEL_RESET;
    cur_period = PWM_PERIOD_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unarmed_bytes();
    test_full_frame();
    test_config_extremes();
    test_random_frames();
    test_start_code_nonzero();
    test_broken_frames();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && duty_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dmxrx_pkg.sv
rtl/core/dmxrx_frame_ctrl.sv
rtl/core/dmxrx_duty_calc.sv
rtl/core/dmx_rgb_channel_receiver.sv
rtl/core/dmxrx_port_checker.sv
verif/dmx_rgb_channel_receiver_tb.sv
